// ===== design/cuckoo_hash_table_assert.svh =====
// assertion macros for the cuckoo hash table
// used by the top level; expects clk and rst_n in scope
`ifndef CUCKOO_HASH_TABLE_ASSERT_SVH
`define CUCKOO_HASH_TABLE_ASSERT_SVH

// same-cycle implication, idle during reset
`define CH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cuckoo hash table check failed");

// next-cycle implication, idle during reset
`define CH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cuckoo hash table check failed");

`endif

// ===== design/ch_pkg.sv =====
// shared types, constants and register codes for the cuckoo hash table
// no dependencies
package ch_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int TABLE_COUNT_DEF = 5;
    localparam int KEY_W           = 31;
    localparam int SIZE_W          = 9;
    localparam int NTAB_W          = 3;
    localparam int MOVES_W         = 8;
    localparam int SIZE_REGS       = 5;
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_DATA_W      = 32;

    // modulo unit: key bits handled per cycle
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_PAD_W     = 32;
    localparam int MOD_STEPS     = MOD_PAD_W / MOD_STEP_BITS;
    localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

    localparam logic [NTAB_W-1:0]  NUM_TABLES_RST = 3'd5;
    localparam logic [SIZE_W-1:0]  SIZE_RST       = 9'd256;
    localparam logic [MOVES_W-1:0] MAX_MOVES_RST  = 8'd50;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_NUM_TABLES = 3'd0,
        REG_SIZE_ZERO  = 3'd1,
        REG_SIZE_ONE   = 3'd2,
        REG_SIZE_TWO   = 3'd3,
        REG_SIZE_THREE = 3'd4,
        REG_SIZE_FOUR  = 3'd5,
        REG_MAX_MOVES  = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOP,
        ST_MODW,
        ST_RD,
        ST_CHK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic             found;
        logic             status;
        logic [KEY_W-1:0] leftover_key;
    } out_t;

    // modulo unit request
    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } mod_req_t;

    // modulo unit response
    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] rem;
    } mod_rsp_t;

endpackage

// ===== design/cuckoo_hash_table.sv =====
// cuckoo hash table top level: apb registers, sequencer, slot store
// depends on ch_pkg, ch_mod_unit, ch_slot_ram, cuckoo_hash_table_assert.svh
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_data (action, key)
// out       output     out_valid / out_stall out_data (found, status, leftover_key)
// cfg       apb        psel/penable/pwrite   paddr, pwdata, prdata
//
// after reset the store is cleared, one entry a cycle, all TABLE_COUNT*TABLE_DEPTH
// entries (1280 by default), before the first transaction is taken.
// each table probe runs the key through the shared modulo unit, then reads
// and checks the slot. insert: up to max_moves probes; remove and search:
// one probe per table in use. one transaction at a time; the result
// register lets the next transaction start while a result is stalled.
`include "cuckoo_hash_table_assert.svh"

module cuckoo_hash_table
#(
    parameter int TABLE_DEPTH = ch_pkg::TABLE_DEPTH_DEF,
    parameter int TABLE_COUNT = ch_pkg::TABLE_COUNT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ch_pkg::in_t                     in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ch_pkg::out_t                    out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ch_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ch_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ch_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                            pready
);

    localparam int ENTRIES = TABLE_DEPTH * TABLE_COUNT;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KW      = ch_pkg::KEY_W;

    // configuration registers
    logic [ch_pkg::NTAB_W-1:0]  num_tables_reg;
    logic [ch_pkg::SIZE_W-1:0]  size_reg [ch_pkg::SIZE_REGS];
    logic [ch_pkg::MOVES_W-1:0] max_moves_reg;
    logic                       cfg_wr;
    ch_pkg::reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = ch_pkg::reg_idx_t'(paddr[4:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_tables_reg <= ch_pkg::NUM_TABLES_RST;
            max_moves_reg  <= ch_pkg::MAX_MOVES_RST;
            for (int i = 0; i < ch_pkg::SIZE_REGS; i++)
                size_reg[i] <= ch_pkg::SIZE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                ch_pkg::REG_NUM_TABLES: num_tables_reg <= pwdata[ch_pkg::NTAB_W-1:0];
                ch_pkg::REG_SIZE_ZERO:  size_reg[0] <= pwdata[ch_pkg::SIZE_W-1:0];
                ch_pkg::REG_SIZE_ONE:   size_reg[1] <= pwdata[ch_pkg::SIZE_W-1:0];
                ch_pkg::REG_SIZE_TWO:   size_reg[2] <= pwdata[ch_pkg::SIZE_W-1:0];
                ch_pkg::REG_SIZE_THREE: size_reg[3] <= pwdata[ch_pkg::SIZE_W-1:0];
                ch_pkg::REG_SIZE_FOUR:  size_reg[4] <= pwdata[ch_pkg::SIZE_W-1:0];
                ch_pkg::REG_MAX_MOVES:  max_moves_reg <= pwdata[ch_pkg::MOVES_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            ch_pkg::REG_NUM_TABLES: prdata = 32'(num_tables_reg);
            ch_pkg::REG_SIZE_ZERO:  prdata = 32'(size_reg[0]);
            ch_pkg::REG_SIZE_ONE:   prdata = 32'(size_reg[1]);
            ch_pkg::REG_SIZE_TWO:   prdata = 32'(size_reg[2]);
            ch_pkg::REG_SIZE_THREE: prdata = 32'(size_reg[3]);
            ch_pkg::REG_SIZE_FOUR:  prdata = 32'(size_reg[4]);
            ch_pkg::REG_MAX_MOVES:  prdata = 32'(max_moves_reg);
            default:                prdata = '0;
        endcase
    end

    // sequencer state
    ch_pkg::state_t              state_reg, state_next;
    logic [1:0]                  action_reg, action_next;
    logic [KW-1:0]               key_reg, key_next;
    logic [ch_pkg::MOVES_W-1:0]  moves_reg, moves_next;
    logic [ch_pkg::NTAB_W-1:0]   t_reg, t_next;
    logic                        found_reg, found_next;
    logic                        status_reg, status_next;
    logic [ADDR_W-1:0]           clr_reg, clr_next;
    logic [ch_pkg::SIZE_W-1:0]   rem_reg, rem_next;
    logic                        out_valid_reg, out_valid_next;
    ch_pkg::out_t                out_data_reg, out_data_next;

    logic [ch_pkg::NTAB_W-1:0]   ntab;
    logic [ch_pkg::SIZE_W-1:0]   size_raw, size_eff;
    logic [ADDR_W-1:0]           slot_addr;
    ch_pkg::mod_req_t            mod_req;
    ch_pkg::mod_rsp_t            mod_rsp;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [KW:0]                 wr_data;
    logic [KW:0]                 rd_data;
    logic                        in_take;
    logic                        hit;

    // tables in use and the selected table's size, clamped
    always_comb
    begin
        if (num_tables_reg == '0)
            ntab = ch_pkg::NTAB_W'(1);
        else if (32'(num_tables_reg) > TABLE_COUNT)
            ntab = ch_pkg::NTAB_W'(TABLE_COUNT);
        else
            ntab = num_tables_reg;
        size_raw = size_reg[t_reg];
        if (size_raw == '0)
            size_eff = ch_pkg::SIZE_W'(1);
        else if (32'(size_raw) > TABLE_DEPTH)
            size_eff = ch_pkg::SIZE_W'(TABLE_DEPTH);
        else
            size_eff = size_raw;
    end

    assign slot_addr = ADDR_W'(32'(t_reg) * TABLE_DEPTH + 32'(rem_reg));
    assign hit       = rd_data[KW] && (rd_data[KW-1:0] == key_reg);
    assign in_stall  = (state_reg != ch_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;

    ch_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    ch_slot_ram
    #(
        .DEPTH  (ENTRIES),
        .ADDR_W (ADDR_W)
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (slot_addr),
        .rd_data (rd_data)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ch_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction payload registers
    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        key_reg      <= key_next;
        moves_reg    <= moves_next;
        t_reg        <= t_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        key_next       = key_reg;
        moves_next     = moves_reg;
        t_next         = t_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        clr_next       = clr_reg;
        rem_next       = rem_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        mod_req.start    = 1'b0;
        mod_req.dividend = key_reg;
        mod_req.divisor  = size_eff;
        wr_en   = 1'b0;
        wr_addr = slot_addr;
        wr_data = {1'b1, key_reg};

        case (state_reg)
            // sweep the store empty after reset
            ch_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == ENTRIES - 1)
                    state_next = ch_pkg::ST_IDLE;
            end
            ch_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    action_next = in_data.action;
                    key_next    = in_data.key;
                    moves_next  = '0;
                    t_next      = '0;
                    found_next  = 1'b0;
                    status_next = 1'b0;
                    state_next  = ch_pkg::ST_LOOP;
                end
            end
            // decide the next probe or finish
            ch_pkg::ST_LOOP:
            begin
                case (action_reg)
                    ch_pkg::ACT_INSERT:
                    begin
                        if (moves_reg >= max_moves_reg)
                        begin
                            status_next = 1'b1;
                            state_next  = ch_pkg::ST_FIN;
                        end
                        else
                        begin
                            mod_req.start = 1'b1;
                            state_next    = ch_pkg::ST_MODW;
                        end
                    end
                    ch_pkg::ACT_REMOVE, ch_pkg::ACT_SEARCH:
                    begin
                        if (t_reg >= ntab)
                            state_next = ch_pkg::ST_FIN;
                        else
                        begin
                            mod_req.start = 1'b1;
                            state_next    = ch_pkg::ST_MODW;
                        end
                    end
                    default: state_next = ch_pkg::ST_FIN;
                endcase
            end
            ch_pkg::ST_MODW:
            begin
                if (mod_rsp.done)
                begin
                    rem_next   = mod_rsp.rem;
                    state_next = ch_pkg::ST_RD;
                end
            end
            ch_pkg::ST_RD:
            begin
                state_next = ch_pkg::ST_CHK;
            end
            // slot data is back
            ch_pkg::ST_CHK:
            begin
                state_next = ch_pkg::ST_LOOP;
                case (action_reg)
                    ch_pkg::ACT_INSERT:
                    begin
                        wr_en = 1'b1;
                        if (!rd_data[KW])
                            state_next = ch_pkg::ST_FIN;
                        else
                        begin
                            // evict the occupant and carry it on
                            key_next   = rd_data[KW-1:0];
                            moves_next = moves_reg + 1'b1;
                            if (t_reg + 1'b1 >= ntab)
                                t_next = '0;
                            else
                                t_next = t_reg + 1'b1;
                        end
                    end
                    ch_pkg::ACT_REMOVE:
                    begin
                        wr_en   = hit;
                        wr_data = '0;
                        t_next  = t_reg + 1'b1;
                    end
                    default:
                    begin
                        if (hit)
                            found_next = 1'b1;
                        t_next = t_reg + 1'b1;
                    end
                endcase
            end
            // hand the result to the output register
            ch_pkg::ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.found        = found_reg;
                    out_data_next.status       = status_reg;
                    out_data_next.leftover_key = status_reg ? key_reg : '0;
                    state_next                 = ch_pkg::ST_IDLE;
                end
            end
            default: state_next = ch_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `CH_ASSERT_NOW(a_fail_used_moves, (state_reg == ch_pkg::ST_FIN) && status_reg, moves_reg >= max_moves_reg)
    `CH_ASSERT_NOW(a_chk_after_rd, state_reg == ch_pkg::ST_CHK, $past(state_reg) == ch_pkg::ST_RD)
    `CH_ASSERT_NOW(a_found_not_fail, out_valid_reg && out_data_reg.found, !out_data_reg.status)

endmodule

// ===== design/ch_mod_unit.sv =====
// iterative modulo unit: key mod table size, a few bits per cycle
// depends on ch_pkg
module ch_mod_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  ch_pkg::mod_req_t  req,
    output ch_pkg::mod_rsp_t  rsp
);

    logic                          busy_reg, busy_next;
    logic [ch_pkg::MOD_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ch_pkg::MOD_PAD_W-1:0]  num_reg, num_next;
    logic [ch_pkg::SIZE_W-1:0]     div_reg, div_next;
    logic [ch_pkg::SIZE_W-1:0]     rem_reg, rem_next;
    logic                          done_reg, done_next;
    logic [ch_pkg::SIZE_W:0]       r;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    // restoring remainder steps, shifted remainder stays below twice the divisor, kept one below it
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        r         = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = {1'b0, req.dividend};
            div_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            r = {1'b0, rem_reg};
            for (int i = 0; i < ch_pkg::MOD_STEP_BITS; i++)
            begin
                r = {r[ch_pkg::SIZE_W-1:0],
                     num_reg[ch_pkg::MOD_PAD_W-1-i]};
                if (r >= {1'b0, div_reg})
                    r = r - {1'b0, div_reg};
            end
            rem_next = r[ch_pkg::SIZE_W-1:0];
            num_next = num_reg << ch_pkg::MOD_STEP_BITS;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ch_pkg::MOD_CNT_W'(ch_pkg::MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== design/ch_slot_ram.sv =====
// slot store: valid bit and key per entry, one write and one registered read
// depends on ch_pkg
module ch_slot_ram
#(
    parameter int DEPTH  = ch_pkg::TABLE_DEPTH_DEF * ch_pkg::TABLE_COUNT_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [ch_pkg::KEY_W:0]    wr_data,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [ch_pkg::KEY_W:0]    rd_data
);

    logic [ch_pkg::KEY_W:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
